### hdl/battery_voltage_charge_monitor_defines.svh
// assertion helpers for the battery monitor checker
`ifndef BATTERY_VOLTAGE_CHARGE_MONITOR_DEFINES_SVH
`define BATTERY_VOLTAGE_CHARGE_MONITOR_DEFINES_SVH

// same-cycle implication
`define BVCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bvcm check failed");

// next-cycle implication
`define BVCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bvcm check failed");

`endif

### hdl/bvcm_pkg.sv
`default_nettype none
package bvcm_pkg;

  localparam int ADC_BITS    = 12;
  localparam int ADC_FULL    = (1 << ADC_BITS) - 1;
  localparam int MV_SCALE    = 3300;
  localparam int MV_SCALE_W  = 12;
  localparam int NUM_W       = ADC_BITS + MV_SCALE_W;
  localparam int RECIP_SHIFT = 2 * ADC_BITS;
  localparam int QEST_W      = NUM_W - ADC_BITS + 1;
  localparam int MV_W        = 12;
  localparam int PACK_W      = 16;
  localparam int CHG_W       = 14;
  localparam int CHG_FRAC    = 10;
  localparam int CHG_Q_W     = 24;
  localparam int CHG_MAX     = 10000;
  localparam int DIV3_MUL    = 2184550;
  localparam int DIV3_SHIFT  = 17;
  localparam int DIV_STEPS   = PACK_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT  = 3'd4;

  localparam logic [15:0] ALPHA_RST = 16'd6554;
  localparam logic [12:0] RATIO_RST = 13'd1024;
  localparam logic [3:0]  CELLS_RST = 4'd3;
  localparam logic [12:0] LOW_RST   = 13'd3500;
  localparam logic [12:0] CRIT_RST  = 13'd3300;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic                sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [PACK_W-1:0] pack_mv;
    logic [PACK_W-1:0] cell_mv;
    logic [CHG_W-1:0]  charge_hundredths;
    logic              is_low;
    logic              is_critical;
  } out_item_t;

  typedef struct packed {
    logic [15:0] filter_alpha;
    logic [12:0] divider_ratio;
    logic [3:0]  cells_in_series;
    logic [12:0] low_cell_mv;
    logic [12:0] critical_cell_mv;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL_MV,
    OP_QEST,
    OP_QFIX,
    OP_MUL_RATIO,
    OP_SCALE,
    OP_MUL_PACK,
    OP_PACK_UPD,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_MUL_CURVE,
    OP_CURVE,
    OP_MUL_CHG,
    OP_CHG_UPD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

endpackage
`default_nettype wire

### hdl/bvcm_cfg.sv
`default_nettype none
module bvcm_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [bvcm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [bvcm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bvcm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output bvcm_pkg::cfg_t                     cfg
);

  bvcm_pkg::cfg_t cfg_r;
  bvcm_pkg::cfg_t cfg_nxt;
  logic [bvcm_pkg::CFG_IDX_W-1:0] idx;

  assign idx    = paddr[bvcm_pkg::CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite && pready) begin
      unique case (idx)
        bvcm_pkg::REG_ALPHA: cfg_nxt.filter_alpha     = pwdata[15:0];
        bvcm_pkg::REG_RATIO: cfg_nxt.divider_ratio    = pwdata[12:0];
        bvcm_pkg::REG_CELLS: cfg_nxt.cells_in_series  = pwdata[3:0];
        bvcm_pkg::REG_LOW:   cfg_nxt.low_cell_mv      = pwdata[12:0];
        bvcm_pkg::REG_CRIT:  cfg_nxt.critical_cell_mv = pwdata[12:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bvcm_pkg::REG_ALPHA: prdata = 32'(cfg_r.filter_alpha);
      bvcm_pkg::REG_RATIO: prdata = 32'(cfg_r.divider_ratio);
      bvcm_pkg::REG_CELLS: prdata = 32'(cfg_r.cells_in_series);
      bvcm_pkg::REG_LOW:   prdata = 32'(cfg_r.low_cell_mv);
      bvcm_pkg::REG_CRIT:  prdata = 32'(cfg_r.critical_cell_mv);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_alpha     <= bvcm_pkg::ALPHA_RST;
      cfg_r.divider_ratio    <= bvcm_pkg::RATIO_RST;
      cfg_r.cells_in_series  <= bvcm_pkg::CELLS_RST;
      cfg_r.low_cell_mv      <= bvcm_pkg::LOW_RST;
      cfg_r.critical_cell_mv <= bvcm_pkg::CRIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/bvcm_ctrl.sv
`default_nettype none
module bvcm_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  bvcm_pkg::ctrl_status_t    status,
  output bvcm_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_MV,
    S_QEST,
    S_QFIX,
    S_MUL_RATIO,
    S_SCALE,
    S_MUL_PACK,
    S_PACK_UPD,
    S_DIV_LOAD,
    S_DIV_STEP,
    S_MUL_CURVE,
    S_CURVE,
    S_MUL_CHG,
    S_CHG_UPD,
    S_OUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [bvcm_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd.op      = bvcm_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bvcm_pkg::OP_LATCH;
          state_nxt = S_MUL_MV;
        end
      end
      S_MUL_MV: begin
        cmd.op    = bvcm_pkg::OP_MUL_MV;
        state_nxt = S_QEST;
      end
      S_QEST: begin
        cmd.op    = bvcm_pkg::OP_QEST;
        state_nxt = S_QFIX;
      end
      S_QFIX: begin
        cmd.op    = bvcm_pkg::OP_QFIX;
        state_nxt = S_MUL_RATIO;
      end
      S_MUL_RATIO: begin
        cmd.op    = bvcm_pkg::OP_MUL_RATIO;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = bvcm_pkg::OP_SCALE;
        state_nxt = S_MUL_PACK;
      end
      S_MUL_PACK: begin
        cmd.op    = bvcm_pkg::OP_MUL_PACK;
        state_nxt = S_PACK_UPD;
      end
      S_PACK_UPD: begin
        cmd.op    = bvcm_pkg::OP_PACK_UPD;
        state_nxt = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.op      = bvcm_pkg::OP_DIV_LOAD;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op      = bvcm_pkg::OP_DIV_STEP;
        div_cnt_nxt = div_cnt_r + bvcm_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == bvcm_pkg::DIV_CNT_W'(bvcm_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_MUL_CURVE;
        end
      end
      S_MUL_CURVE: begin
        cmd.op    = bvcm_pkg::OP_MUL_CURVE;
        state_nxt = S_CURVE;
      end
      S_CURVE: begin
        cmd.op    = bvcm_pkg::OP_CURVE;
        state_nxt = S_MUL_CHG;
      end
      S_MUL_CHG: begin
        cmd.op    = bvcm_pkg::OP_MUL_CHG;
        state_nxt = S_CHG_UPD;
      end
      S_CHG_UPD: begin
        cmd.op    = bvcm_pkg::OP_CHG_UPD;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op    = bvcm_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/bvcm_dp.sv
`default_nettype none
module bvcm_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  bvcm_pkg::in_item_t      in_data,
  input  bvcm_pkg::cfg_t          cfg,
  input  bvcm_pkg::ctrl_cmd_t     cmd,
  output bvcm_pkg::ctrl_status_t  status,
  output logic                    out_valid,
  input  wire                     out_stall,
  output bvcm_pkg::out_item_t     out_data
);

  localparam int ADC_BITS = bvcm_pkg::ADC_BITS;
  localparam int NUM_W    = bvcm_pkg::NUM_W;
  localparam int QEST_W   = bvcm_pkg::QEST_W;
  localparam int MV_W     = bvcm_pkg::MV_W;
  localparam int PACK_W   = bvcm_pkg::PACK_W;
  localparam int CHG_W    = bvcm_pkg::CHG_W;
  localparam int CHG_Q_W  = bvcm_pkg::CHG_Q_W;
  localparam int FRAC     = bvcm_pkg::CHG_FRAC;
  localparam logic [CHG_Q_W-1:0] CHG_Q_MAX = CHG_Q_W'(bvcm_pkg::CHG_MAX << FRAC);

  // sequencer-owned state
  logic                  primed_r;
  logic [31:0]           pf_r;
  logic [CHG_Q_W-1:0]    cf_r;
  logic                  out_valid_r;

  // working registers
  logic [ADC_BITS-1:0]   samp_r;
  logic                  svalid_r;
  logic [QEST_W-1:0]     q_r;
  logic [MV_W-1:0]       mv_r;
  logic [PACK_W-1:0]     x_r;
  logic signed [50:0]    prod_r;
  logic [4:0]            rem_r;
  logic [PACK_W-1:0]     quo_r;
  logic [3:0]            divisor_r;
  logic [CHG_W-1:0]      chg_r;
  bvcm_pkg::out_item_t   out_r;

  // shared multiplier
  logic signed [32:0]    mul_a;
  logic [16:0]           mul_b;
  logic signed [50:0]    prod;

  logic signed [32:0]    pack_diff;
  logic signed [32:0]    chg_diff;
  logic [CHG_Q_W-1:0]    chg_x;
  logic [NUM_W-1:0]      num;
  logic [NUM_W+ADC_BITS:0] recip_sum;
  logic [NUM_W:0]        qmul;
  logic [NUM_W:0]        resid;
  logic [16:0]           scaled;
  logic [34:0]           pf_sum;
  logic [34:0]           cf_sum;
  logic [CHG_Q_W-1:0]    cf_new;
  logic [8:0]            curve_d;
  logic [7:0]            seg_hi;
  logic [7:0]            seg_lo;
  logic [8:0]            seg_low;
  logic [CHG_W-1:0]      chg_nxt;
  logic [4:0]            div_rem;
  logic [PACK_W-1:0]     div_quo;
  logic [3:0]            cells;

  assign num       = prod_r[NUM_W-1:0];
  assign pack_diff = $signed({1'b0, x_r, 16'b0}) - $signed({1'b0, pf_r});
  assign chg_x     = {chg_r, {FRAC{1'b0}}};
  assign chg_diff  = $signed({9'b0, chg_x}) - $signed({9'b0, cf_r});
  assign curve_d   = 9'(quo_r - 16'd3700);
  assign cells     = (cfg.cells_in_series == 4'd0) ? 4'd1 : cfg.cells_in_series;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      bvcm_pkg::OP_MUL_MV: begin
        mul_a = 33'(bvcm_pkg::MV_SCALE);
        mul_b = 17'(samp_r);
      end
      bvcm_pkg::OP_MUL_RATIO: begin
        mul_a = {20'b0, cfg.divider_ratio};
        mul_b = 17'(mv_r);
      end
      bvcm_pkg::OP_MUL_PACK: begin
        mul_a = pack_diff;
        mul_b = {1'b0, cfg.filter_alpha};
      end
      bvcm_pkg::OP_MUL_CURVE: begin
        mul_a = 33'(bvcm_pkg::DIV3_MUL);
        mul_b = 17'(curve_d);
      end
      bvcm_pkg::OP_MUL_CHG: begin
        mul_a = chg_diff;
        mul_b = {1'b0, cfg.filter_alpha};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * $signed({1'b0, mul_b});

  // divide by full scale through its reciprocal, then one correction
  assign recip_sum = {1'b0, num, {ADC_BITS{1'b0}}} + (NUM_W + ADC_BITS + 1)'(num);
  assign qmul      = {q_r, {ADC_BITS{1'b0}}} - (NUM_W + 1)'(q_r);
  assign resid     = (NUM_W + 1)'(num) - qmul;

  assign scaled = prod_r[24:8];
  assign pf_sum = {3'b000, pf_r} + 35'(prod_r[50:16]);
  assign cf_sum = {11'b0, cf_r} + 35'(prod_r[50:16]);
  assign cf_new = (cf_sum[CHG_Q_W-1:0] > CHG_Q_MAX) ? CHG_Q_MAX : cf_sum[CHG_Q_W-1:0];

  // two restoring division steps per cycle
  always_comb begin
    div_rem = rem_r;
    div_quo = quo_r;
    for (int i = 0; i < 2; i++) begin
      div_rem = {div_rem[3:0], div_quo[PACK_W-1]};
      div_quo = {div_quo[PACK_W-2:0], 1'b0};
      if (div_rem >= {1'b0, divisor_r}) begin
        div_rem    = div_rem - {1'b0, divisor_r};
        div_quo[0] = 1'b1;
      end
    end
  end

  // lipo curve
  assign seg_hi  = 8'(quo_r - 16'd4000);
  assign seg_lo  = 8'(quo_r - 16'd3500);
  assign seg_low = 9'(quo_r - 16'd3000);

  always_comb begin
    if (quo_r >= 16'd4200) begin
      chg_nxt = 14'd10000;
    end else if (quo_r <= 16'd3000) begin
      chg_nxt = 14'd0;
    end else if (quo_r >= 16'd4000) begin
      chg_nxt = 14'd8000 + 14'(seg_hi) * 14'd10;
    end else if (quo_r >= 16'd3700) begin
      chg_nxt = 14'd3000 + prod_r[bvcm_pkg::DIV3_SHIFT+CHG_W-1:bvcm_pkg::DIV3_SHIFT];
    end else if (quo_r >= 16'd3500) begin
      chg_nxt = 14'd1000 + 14'(seg_lo) * 14'd10;
    end else begin
      chg_nxt = {4'b0, seg_low, 1'b0};
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      pf_r        <= '0;
      cf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == bvcm_pkg::OP_PACK_UPD && svalid_r) begin
        pf_r <= primed_r ? pf_sum[31:0] : {x_r, 16'b0};
      end
      if (cmd.op == bvcm_pkg::OP_CHG_UPD && (svalid_r || primed_r)) begin
        cf_r     <= primed_r ? cf_new : ((chg_x > CHG_Q_MAX) ? CHG_Q_MAX : chg_x);
        primed_r <= 1'b1;
      end
      if (cmd.op == bvcm_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bvcm_pkg::OP_LATCH: begin
        samp_r   <= in_data.adc_sample;
        svalid_r <= in_data.sample_valid;
      end
      bvcm_pkg::OP_MUL_MV,
      bvcm_pkg::OP_MUL_RATIO,
      bvcm_pkg::OP_MUL_PACK,
      bvcm_pkg::OP_MUL_CURVE,
      bvcm_pkg::OP_MUL_CHG: prod_r <= prod;
      bvcm_pkg::OP_QEST: q_r <= recip_sum[NUM_W+ADC_BITS:bvcm_pkg::RECIP_SHIFT];
      bvcm_pkg::OP_QFIX: begin
        mv_r <= (resid >= (NUM_W + 1)'(bvcm_pkg::ADC_FULL)) ?
                q_r[MV_W-1:0] + MV_W'(1) : q_r[MV_W-1:0];
      end
      bvcm_pkg::OP_SCALE: x_r <= scaled[16] ? 16'hFFFF : scaled[15:0];
      bvcm_pkg::OP_DIV_LOAD: begin
        quo_r     <= pf_r[31:16];
        rem_r     <= '0;
        divisor_r <= cells;
      end
      bvcm_pkg::OP_DIV_STEP: begin
        quo_r <= div_quo;
        rem_r <= div_rem;
      end
      bvcm_pkg::OP_CURVE: chg_r <= chg_nxt;
      bvcm_pkg::OP_OUT: begin
        out_r.pack_mv           <= pf_r[31:16];
        out_r.cell_mv           <= quo_r;
        out_r.charge_hundredths <= cf_r[CHG_Q_W-1:FRAC];
        out_r.is_low            <= (quo_r < {3'b000, cfg.low_cell_mv});
        out_r.is_critical       <= (quo_r < {3'b000, cfg.critical_cell_mv});
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/battery_voltage_charge_monitor.sv
// sequence: latch, mv multiply, quotient estimate and fix, ratio multiply, scale,
// pack filter, divide load and eight steps, curve, charge filter, out (held while
// out_stall blocks the output); no new sample is taken until idle; it runs on the
// single shared 33x17 multiplier and the two-bit-per-cycle cell count divider
// reset: synchronous active low, filters and primed flag cleared, config to defaults
`default_nettype none
module battery_voltage_charge_monitor (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  bvcm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output bvcm_pkg::out_item_t                out_data,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [bvcm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [bvcm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bvcm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  bvcm_pkg::cfg_t         cfg;
  bvcm_pkg::ctrl_cmd_t    cmd;
  bvcm_pkg::ctrl_status_t status;

  bvcm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bvcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bvcm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### hdl/bvcm_checker.sv
`default_nettype none
`include "battery_voltage_charge_monitor_defines.svh"
module bvcm_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input bvcm_pkg::out_item_t out_data
);

  `BVCM_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
  `BVCM_ASSERT_IMPL(a_charge_range, out_valid, out_data.charge_hundredths <= 14'd10000)
  `BVCM_ASSERT_IMPL(a_cell_le_pack, out_valid, out_data.cell_mv <= out_data.pack_mv)
  `BVCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind battery_voltage_charge_monitor bvcm_checker u_bvcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
